### hw/rtl/dtc_pkg.sv
// Decision tree classifier package: operation codes and transaction payload types.
// Depends on nothing; used by the top level and the testbench.
package dtc_pkg;

	localparam logic [1:0] OP_WRITE_NODE    = 2'd0;
	localparam logic [1:0] OP_WRITE_FEATURE = 2'd1;
	localparam logic [1:0] OP_CLASSIFY      = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [9:0]         node_index;
		logic               is_leaf;
		logic [5:0]         feature_index;
		logic signed [31:0] threshold;
		logic [9:0]         left_child;
		logic [9:0]         right_child;
		logic [3:0]         class_label;
		logic signed [31:0] feature_value;
	} req_t;

	typedef struct packed {
		logic [3:0] predicted_class;
		logic       walk_error;
	} rsp_t;

endpackage

### hw/rtl/dtc_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is set per instance (dtc_pkg::req_t or dtc_pkg::rsp_t).
interface dtc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/decision_tree_classifier.sv
// Decision tree classifier top level: node table, feature store and walk sequencer.
// Depends on dtc_pkg and dtc_stream_if.
//
// Channel  Dir  Payload          Transaction
// cmd      in   dtc_pkg::req_t   write node, write feature or classify
// res      out  dtc_pkg::rsp_t   predicted_class and walk_error, one per classify
//
// For a classify, each inner node on the path takes one level of the walk:
// each level reads the node table, then the feature store, then compares.
// cmd.ready is low from a classify until its result sits in the output register.
// A stalled res holds the walk in its final state; reset clears control only,
// both tables stay undefined until written and get no clearing pass.
module decision_tree_classifier #(
	parameter int MAX_NODES    = 1024,
	parameter int MAX_FEATURES = 64,
	parameter int FEATURE_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	dtc_stream_if.sink   cmd,
	dtc_stream_if.source res
);

	localparam int VAL_BITS = (FEATURE_BITS < 32) ? FEATURE_BITS : 32;
	localparam int NODE_AW  = $clog2(MAX_NODES);
	localparam int FEAT_AW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam logic [31:0] NODE_LIMIT = 32'(MAX_NODES);
	localparam logic [31:0] FEAT_LIMIT = 32'(MAX_FEATURES);
	localparam logic [NODE_AW-1:0] VISIT_LAST = NODE_AW'(MAX_NODES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_NODE = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	typedef struct packed {
		logic                       leaf;
		logic [5:0]                 feat;
		logic signed [VAL_BITS-1:0] thr;
		logic [9:0]                 left;
		logic [9:0]                 right;
		logic [3:0]                 cls;
	} node_t;

	node_t                      node_mem [MAX_NODES];
	logic signed [VAL_BITS-1:0] feat_mem [MAX_FEATURES];

	logic [1:0]                 state_q, state_d;
	logic [NODE_AW-1:0]         visit_q, visit_d;
	node_t                      node_rd_q;
	logic signed [VAL_BITS-1:0] feat_rd_q;
	logic                       feat_ok_q;
	logic [3:0]                 res_cls_q, res_cls_d;
	logic                       res_err_q, res_err_d;
	logic                       res_valid_q;
	dtc_pkg::rsp_t              res_data_q;

	logic                       cmd_fire;
	logic                       node_we, feat_we, classify;
	logic [31:0]                nidx_w, fidx_w, feat_w, child_w;
	logic [NODE_AW-1:0]         node_waddr, node_addr;
	logic [FEAT_AW-1:0]         feat_waddr, feat_addr;
	node_t                      node_wr;
	logic signed [VAL_BITS-1:0] fv;
	logic                       go_left, child_ok, node_ld, out_free;
	logic [9:0]                 child;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign nidx_w     = 32'(cmd.data.node_index);
	assign fidx_w     = 32'(cmd.data.feature_index);
	assign node_waddr = nidx_w[NODE_AW-1:0];
	assign feat_waddr = fidx_w[FEAT_AW-1:0];

	always_comb begin
		node_we  = 1'b0;
		feat_we  = 1'b0;
		classify = 1'b0;
		unique case (cmd.data.opcode)
			dtc_pkg::OP_WRITE_NODE:    node_we  = cmd_fire && (nidx_w < NODE_LIMIT);
			dtc_pkg::OP_WRITE_FEATURE: feat_we  = cmd_fire && (fidx_w < FEAT_LIMIT);
			dtc_pkg::OP_CLASSIFY:      classify = cmd_fire;
			default: begin
			end
		endcase
	end

	always_comb begin
		node_wr.leaf  = cmd.data.is_leaf;
		node_wr.feat  = cmd.data.feature_index;
		node_wr.thr   = cmd.data.threshold[VAL_BITS-1:0];
		node_wr.left  = cmd.data.left_child;
		node_wr.right = cmd.data.right_child;
		node_wr.cls   = cmd.data.class_label;
	end

	// Compare and child selection
	assign fv       = feat_ok_q ? feat_rd_q : '0;
	assign go_left  = fv < node_rd_q.thr;
	assign child    = go_left ? node_rd_q.left : node_rd_q.right;
	assign child_w  = 32'(child);
	assign child_ok = child_w < NODE_LIMIT;

	assign feat_w    = 32'(node_rd_q.feat);
	assign feat_addr = feat_w[FEAT_AW-1:0];
	assign out_free  = !res_valid_q || res.ready;

	always_comb begin
		state_d   = state_q;
		visit_d   = visit_q;
		res_cls_d = res_cls_q;
		res_err_d = res_err_q;
		node_ld   = 1'b0;
		node_addr = child_w[NODE_AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				node_addr = '0;
				if (classify) begin
					node_ld = 1'b1;
					visit_d = '0;
					state_d = S_NODE;
				end
			end
			S_NODE: begin
				if (node_rd_q.leaf) begin
					res_cls_d = node_rd_q.cls;
					res_err_d = 1'b0;
					state_d   = S_DONE;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (!child_ok || (visit_q == VISIT_LAST)) begin
					res_cls_d = '0;
					res_err_d = 1'b1;
					state_d   = S_DONE;
				end else begin
					node_ld = 1'b1;
					visit_d = visit_q + 1'b1;
					state_d = S_NODE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			visit_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			visit_q <= visit_d;
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_cls_q <= res_cls_d;
		res_err_q <= res_err_d;
		if (state_q == S_DONE && out_free) begin
			res_data_q.predicted_class <= res_cls_q;
			res_data_q.walk_error      <= res_err_q;
		end
	end

	// Node table: one write, one registered read
	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wr;
		end
		if (node_ld) begin
			node_rd_q <= node_mem[node_addr];
		end
	end

	// Feature store: one write, one registered read
	always_ff @(posedge clk) begin
		if (feat_we) begin
			feat_mem[feat_waddr] <= cmd.data.feature_value[VAL_BITS-1:0];
		end
		feat_rd_q <= feat_mem[feat_addr];
		feat_ok_q <= feat_w < FEAT_LIMIT;
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

`ifndef ASSERT_OFF
	a_cmp_after_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_NODE))
		else $error("compare step not preceded by node read");

	a_classify_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.data.opcode == dtc_pkg::OP_CLASSIFY)
		|=> (state_q == S_NODE))
		else $error("classify transaction did not start a walk");

	a_error_class_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.walk_error) |-> (res.data.predicted_class == '0))
		else $error("walk error with non-zero class");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_free) |=> (state_q == S_DONE && !cmd.ready))
		else $error("finished walk left before the output register was free");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for decision_tree_classifier: plants random trees, chains and loops, then
// predicts every classify walk and checks each result. Depends on dtc_pkg, dtc_stream_if.
module tb_top;

	localparam int TREE_NODES    = 1024;
	localparam int TREE_FEATURES = 64;
	localparam int VALUE_BITS    = 32;
	localparam int ITEM_TARGET   = 1000;
	localparam int STALL_LIMIT   = 20000;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct {
		logic               leaf;
		logic [5:0]         feat;
		logic signed [31:0] thr;
		logic [9:0]         left;
		logic [9:0]         right;
		logic [3:0]         cls;
	} tree_node_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dtc_stream_if #(.payload_t(dtc_pkg::req_t)) cmd_if ();
	dtc_stream_if #(.payload_t(dtc_pkg::rsp_t)) res_if ();

	decision_tree_classifier #(
		.MAX_NODES(TREE_NODES),
		.MAX_FEATURES(TREE_FEATURES),
		.FEATURE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	tree_node_t         tree[TREE_NODES];
	bit                 node_set[TREE_NODES];
	logic signed [31:0] features[TREE_FEATURES];
	bit                 feat_set[TREE_FEATURES];
	logic signed [31:0] last_thr[TREE_FEATURES] = '{default: '0};
	int                 tree_feats[$];
	dtc_pkg::rsp_t      verdict_q[$];
	dtc_pkg::rsp_t      want;
	bit                 calm;
	int                 errors;
	int                 items_sent;
	int                 stall_cycles;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic dtc_pkg::rsp_t walk_tree(output int gap_node, output int gap_feat);
		dtc_pkg::rsp_t      r;
		int                 cur;
		int                 visits;
		logic signed [31:0] fv;
		int                 nxt;
		cur = 0;
		gap_node = -1;
		gap_feat = -1;
		r.predicted_class = 4'd0;
		r.walk_error = 1'b1;
		for (visits = 0; visits < TREE_NODES; visits++) begin
			if (!node_set[cur]) begin
				gap_node = cur;
				return r;
			end
			if (tree[cur].leaf) begin
				r.predicted_class = tree[cur].cls;
				r.walk_error = 1'b0;
				return r;
			end
			fv = '0;
			if (tree[cur].feat < TREE_FEATURES) begin
				if (!feat_set[tree[cur].feat]) begin
					gap_feat = tree[cur].feat;
					return r;
				end
				fv = features[tree[cur].feat];
			end
			nxt = (fv < tree[cur].thr) ? tree[cur].left : tree[cur].right;
			if (nxt >= TREE_NODES)
				break;
			cur = nxt;
		end
		return r;
	endfunction

	function automatic void apply_cmd(dtc_pkg::req_t r);
		int gap_node;
		int gap_feat;
		case (r.opcode)
		dtc_pkg::OP_WRITE_NODE: begin
			if (r.node_index < TREE_NODES) begin
				tree[r.node_index].leaf  = r.is_leaf;
				tree[r.node_index].feat  = r.feature_index;
				tree[r.node_index].thr   = r.threshold;
				tree[r.node_index].left  = r.left_child;
				tree[r.node_index].right = r.right_child;
				tree[r.node_index].cls   = r.class_label;
				node_set[r.node_index]   = 1'b1;
			end
		end
		dtc_pkg::OP_WRITE_FEATURE: begin
			if (r.feature_index < TREE_FEATURES) begin
				features[r.feature_index] = r.feature_value;
				feat_set[r.feature_index] = 1'b1;
			end
		end
		dtc_pkg::OP_CLASSIFY: begin
			verdict_q.push_back(walk_tree(gap_node, gap_feat));
		end
		default: ;
		endcase
	endfunction

	function automatic dtc_pkg::req_t mk_op(logic [1:0] op);
		dtc_pkg::req_t r;
		r.opcode        = op;
		r.node_index    = 10'($urandom);
		r.is_leaf       = 1'($urandom);
		r.feature_index = 6'($urandom);
		r.threshold     = $signed($urandom);
		r.left_child    = 10'($urandom);
		r.right_child   = 10'($urandom);
		r.class_label   = 4'($urandom);
		r.feature_value = $signed($urandom);
		return r;
	endfunction

	function automatic dtc_pkg::req_t mk_node(int idx, int leaf, int feat,
			logic signed [31:0] thr, int left, int right, int cls);
		dtc_pkg::req_t r;
		r = mk_op(dtc_pkg::OP_WRITE_NODE);
		r.node_index    = 10'(idx);
		r.is_leaf       = 1'(leaf);
		r.feature_index = 6'(feat);
		r.threshold     = thr;
		r.left_child    = 10'(left);
		r.right_child   = 10'(right);
		r.class_label   = 4'(cls);
		return r;
	endfunction

	function automatic dtc_pkg::req_t mk_feat(int idx, logic signed [31:0] val);
		dtc_pkg::req_t r;
		r = mk_op(dtc_pkg::OP_WRITE_FEATURE);
		r.feature_index = 6'(idx);
		r.feature_value = val;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_thr();
		case ($urandom_range(0, 4))
		0, 1: return $signed(32'($urandom_range(0, 8))) - 4;
		2: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
		default: return $signed($urandom);
		endcase
	endfunction

	// Bias values towards the last threshold seen on this feature.
	function automatic logic signed [31:0] pick_value(int f);
		case ($urandom_range(0, 5))
		0: return $signed($urandom);
		1: return $signed(32'($urandom_range(0, 8))) - 4;
		2: return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
		default: return last_thr[f] + $signed(32'($urandom_range(0, 2))) - 1;
		endcase
	endfunction

	task automatic send_cmd(input dtc_pkg::req_t r);
		bit rdy;
		while (!calm && $urandom_range(0, 99) < 13) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.data  <= r;
		do begin
			@(negedge clk);
			rdy = cmd_if.ready;
			@(posedge clk);
		end while (!rdy);
		apply_cmd(r);
		if (r.opcode != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (verdict_q.size() != 0);
	endtask

	// Fill any node or feature the walk would touch unwritten, then classify.
	task automatic classify_now();
		int gap_node;
		int gap_feat;
		forever begin
			void'(walk_tree(gap_node, gap_feat));
			if (gap_node >= 0) begin
				send_cmd(mk_node(gap_node, $urandom_range(0, 9) < 7, $urandom_range(0, 63),
					pick_thr(), $urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 15)));
			end else if (gap_feat >= 0) begin
				send_cmd(mk_feat(gap_feat, pick_value(gap_feat)));
			end else begin
				break;
			end
		end
		send_cmd(mk_op(dtc_pkg::OP_CLASSIFY));
	endtask

	task automatic plant_tree();
		int                 idx_q[$];
		int                 lvl_q[$];
		bit                 taken[TREE_NODES];
		int                 kids[2];
		int                 depth;
		int                 budget;
		int                 idx;
		int                 lvl;
		int                 main_side;
		int                 k;
		logic [5:0]         feat;
		logic signed [31:0] thr;
		depth = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
		budget = 60;
		tree_feats.delete();
		idx_q.push_back(0);
		lvl_q.push_back(0);
		taken[0] = 1'b1;
		while (idx_q.size() != 0) begin
			idx = idx_q.pop_front();
			lvl = lvl_q.pop_front();
			if (lvl >= depth || budget == 0) begin
				send_cmd(mk_node(idx, 1, $urandom_range(0, 63), pick_thr(),
					$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 15)));
			end else begin
				budget--;
				main_side = $urandom_range(0, 1);
				for (k = 0; k < 2; k++) begin
					if (k != main_side && $urandom_range(0, 29) == 0) begin
						kids[k] = 0;
					end else begin
						do
							kids[k] = $urandom_range(1, TREE_NODES - 1);
						while (taken[kids[k]]);
						taken[kids[k]] = 1'b1;
						idx_q.push_back(kids[k]);
						lvl_q.push_back((k == main_side || $urandom_range(0, 1)) ? lvl + 1 : depth);
					end
				end
				feat = 6'($urandom);
				thr = pick_thr();
				last_thr[feat] = thr;
				tree_feats.push_back(feat);
				send_cmd(mk_node(idx, 0, feat, thr, kids[0], kids[1], $urandom_range(0, 15)));
			end
		end
	endtask

	task automatic grow_and_walk();
		int rounds;
		int f;
		plant_tree();
		rounds = $urandom_range(15, 40);
		repeat (rounds) begin
			case ($urandom_range(0, 19))
			0: begin
				send_cmd(mk_op(OP_UNUSED));
			end
			1: begin
				send_cmd(mk_node($urandom_range(0, 1023), $urandom_range(0, 1),
					$urandom_range(0, 63), pick_thr(), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 15)));
			end
			2, 3: begin
				f = $urandom_range(0, 63);
				send_cmd(mk_feat(f, pick_value(f)));
			end
			default: begin
				repeat ($urandom_range(0, 2)) begin
					f = tree_feats[$urandom_range(0, tree_feats.size() - 1)];
					send_cmd(mk_feat(f, pick_value(f)));
				end
				classify_now();
			end
			endcase
		end
	endtask

	task automatic test_directed();
		send_cmd(mk_feat(0, VAL_MIN));
		send_cmd(mk_feat(63, VAL_MAX));
		send_cmd(mk_feat(1, 0));
		send_cmd(mk_node(0, 1, 0, 0, 0, 0, 15));
		classify_now();
		send_cmd(mk_node(0, 0, 0, VAL_MIN, 1, 1023, 0));
		send_cmd(mk_node(1, 1, 0, 0, 0, 0, 9));
		send_cmd(mk_node(1023, 1, 0, 0, 0, 0, 0));
		classify_now();
		send_cmd(mk_node(0, 0, 0, VAL_MAX, 1, 1023, 0));
		classify_now();
		send_cmd(mk_feat(0, VAL_MAX));
		classify_now();
		send_cmd(mk_feat(0, VAL_MAX - 1));
		classify_now();
		send_cmd(mk_node(0, 0, 63, 0, 1023, 1, 0));
		classify_now();
		send_cmd(mk_node(0, 0, 1, 0, 0, 0, 0));
		classify_now();
		send_cmd(mk_op(OP_UNUSED));
		classify_now();
	endtask

	task automatic test_looping_walks();
		int depth;
		int k;
		int f;
		depth = $urandom_range(30, 60);
		for (k = 0; k < depth; k++)
			send_cmd(mk_node(k, 0, $urandom_range(0, 63), pick_thr(), k + 1, k + 1, 0));
		send_cmd(mk_node(depth, 1, 0, 0, 0, 0, $urandom_range(0, 15)));
		classify_now();
		send_cmd(mk_node(0, 0, 5, 0, 1, 1, 0));
		send_cmd(mk_node(1, 0, 6, 0, 0, 0, 0));
		classify_now();
		f = $urandom_range(0, 63);
		send_cmd(mk_node(0, 0, f, 0, 0, 1023, 0));
		send_cmd(mk_node(1023, 1, 0, 0, 0, 0, $urandom_range(0, 15)));
		send_cmd(mk_feat(f, -1));
		classify_now();
		send_cmd(mk_feat(f, 0));
		classify_now();
	endtask

	task automatic test_random_walks();
		int pauses;
		pauses = 0;
		while (items_sent < ITEM_TARGET) begin
			grow_and_walk();
			if (pauses == 0 || $urandom_range(0, 2) == 0) begin
				wait_drained();
				pauses++;
			end
		end
	endtask

	task automatic test_unbroken_stream();
		calm = 1'b1;
		grow_and_walk();
		grow_and_walk();
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$error("result with no classify pending: class %0d, error %0d",
						res_if.data.predicted_class, res_if.data.walk_error);
				end else begin
					want = verdict_q.pop_front();
					if (res_if.data.predicted_class !== want.predicted_class) begin
						errors++;
						$error("predicted_class: expected %0d, actual %0d",
							want.predicted_class, res_if.data.predicted_class);
					end
					if (res_if.data.walk_error !== want.walk_error) begin
						errors++;
						$error("walk_error: expected %0d, actual %0d",
							want.walk_error, res_if.data.walk_error);
					end
				end
			end
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
				stall_cycles = 0;
			end else if (++stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			res_if.ready <= calm || ($urandom_range(0, 99) >= 13);
		end
	end

	initial begin
		cmd_if.valid = 1'b0;
		cmd_if.data  = '0;
		res_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_looping_walks();
		test_unbroken_stream();
		test_random_walks();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
